/* rtl/i2cm_pkg.sv */
// Package for the I2C master byte engine: beat types, op codes, bus phase codes
// and configuration register indexes and reset values.
// No dependencies.
package i2cm_pkg;

  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] CFG_TICKS_PER_PHASE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ACK_POLL_LIMIT  = 2'd1;

  localparam logic [15:0] TICKS_PER_PHASE_RESET = 16'd1;
  localparam logic [7:0]  ACK_POLL_LIMIT_RESET  = 8'd250;

  localparam logic [2:0] OP_NONE  = 3'd0;
  localparam logic [2:0] OP_START = 3'd1;
  localparam logic [2:0] OP_STOP  = 3'd2;
  localparam logic [2:0] OP_WRITE = 3'd3;
  localparam logic [2:0] OP_READ  = 3'd4;

  typedef enum logic [18:0] {
    PH_IDLE    = 19'h00001,
    PH_ST0     = 19'h00002,
    PH_ST1     = 19'h00004,
    PH_ST2     = 19'h00008,
    PH_SP0     = 19'h00010,
    PH_SP1     = 19'h00020,
    PH_SP2     = 19'h00040,
    PH_WB_SET  = 19'h00080,
    PH_WB_HIGH = 19'h00100,
    PH_WB_LOW  = 19'h00200,
    PH_WA_REL  = 19'h00400,
    PH_WA_HIGH = 19'h00800,
    PH_WA_POLL = 19'h01000,
    PH_WA_END  = 19'h02000,
    PH_RB_LOW  = 19'h04000,
    PH_RB_HIGH = 19'h08000,
    PH_RA_SET  = 19'h10000,
    PH_RA_HIGH = 19'h20000,
    PH_RA_LOW  = 19'h40000
  } phase_t;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_in;
  } cmd_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       no_ack;
  } rsp_t;

  typedef struct packed {
    phase_t      phase;
    logic [3:0]  bit_count;
    logic [7:0]  shift_reg;
    logic [15:0] phase_timer;
    logic [7:0]  poll_count;
    logic        ack_choice;
    logic        scl_reg;
    logic        sda_reg;
    logic [7:0]  rx_hold;
    logic        nack_flag;
    logic        done;
  } eng_state_t;

endpackage

/* rtl/i2cm_fsm.sv */
// Next-state logic of the I2C master bus sequencer for one tick.
// Depends on i2cm_pkg for the phase codes, op codes and state type.
module i2cm_fsm (
  input  i2cm_pkg::eng_state_t state,
  input  i2cm_pkg::cmd_t       cmd,
  input  logic [15:0]          ticks_per_phase,
  input  logic [7:0]           ack_poll_limit,
  output i2cm_pkg::eng_state_t state_next
);

  // Drive levels {scl, sda} held during each phase.
  function automatic logic [1:0] drive_of(i2cm_pkg::phase_t p, logic b, logic a,
                                          logic [1:0] keep);
    logic [1:0] d;
    d = keep;
    case (p)
      i2cm_pkg::PH_ST0:     d = 2'b11;
      i2cm_pkg::PH_ST1:     d = 2'b10;
      i2cm_pkg::PH_ST2:     d = 2'b00;
      i2cm_pkg::PH_SP0:     d = 2'b00;
      i2cm_pkg::PH_SP1:     d = 2'b10;
      i2cm_pkg::PH_SP2:     d = 2'b11;
      i2cm_pkg::PH_WB_SET:  d = {1'b0, b};
      i2cm_pkg::PH_WB_HIGH: d = {1'b1, b};
      i2cm_pkg::PH_WB_LOW:  d = {1'b0, b};
      i2cm_pkg::PH_WA_REL:  d = 2'b01;
      i2cm_pkg::PH_WA_HIGH: d = 2'b11;
      i2cm_pkg::PH_WA_POLL: d = 2'b11;
      i2cm_pkg::PH_WA_END:  d = 2'b01;
      i2cm_pkg::PH_RB_LOW:  d = 2'b01;
      i2cm_pkg::PH_RB_HIGH: d = 2'b11;
      i2cm_pkg::PH_RA_SET:  d = {1'b0, a};
      i2cm_pkg::PH_RA_HIGH: d = {1'b1, a};
      i2cm_pkg::PH_RA_LOW:  d = {1'b0, a};
      default:              d = keep;
    endcase
    return d;
  endfunction

  logic [15:0]        limit;
  logic [15:0]        timer_inc;
  logic [3:0]         count_inc;
  logic               go;
  i2cm_pkg::phase_t   target;

  assign limit     = (ticks_per_phase == 16'd0) ? 16'd1 : ticks_per_phase;
  assign timer_inc = state.phase_timer + 16'd1;
  assign count_inc = state.bit_count + 4'd1;

  always_comb begin
    state_next      = state;
    state_next.done = 1'b0;
    go              = 1'b0;
    target          = i2cm_pkg::PH_IDLE;

    case (state.phase)
      i2cm_pkg::PH_IDLE: begin
        if (cmd.op inside {[i2cm_pkg::OP_START:i2cm_pkg::OP_READ]}) begin
          state_next.nack_flag  = 1'b0;
          state_next.bit_count  = 4'd0;
          state_next.poll_count = 8'd0;
          state_next.shift_reg  = (cmd.op == i2cm_pkg::OP_WRITE) ? cmd.tx_byte : 8'd0;
          state_next.ack_choice = (cmd.op == i2cm_pkg::OP_READ) ? cmd.send_ack : 1'b0;
          go = 1'b1;
          case (cmd.op)
            i2cm_pkg::OP_START: target = i2cm_pkg::PH_ST0;
            i2cm_pkg::OP_STOP:  target = i2cm_pkg::PH_SP0;
            i2cm_pkg::OP_WRITE: target = i2cm_pkg::PH_WB_SET;
            default:            target = i2cm_pkg::PH_RB_LOW;
          endcase
        end
      end
      i2cm_pkg::PH_WA_POLL: begin
        if (!cmd.sda_in) begin
          go     = 1'b1;
          target = i2cm_pkg::PH_WA_END;
        end else if (state.poll_count >= ack_poll_limit) begin
          state_next.nack_flag = 1'b1;
          go     = 1'b1;
          target = i2cm_pkg::PH_SP0;
        end else begin
          state_next.poll_count = state.poll_count + 8'd1;
        end
      end
      default: begin
        state_next.phase_timer = timer_inc;
        if (timer_inc >= limit) begin
          go = 1'b1;
          case (state.phase)
            i2cm_pkg::PH_ST0:     target = i2cm_pkg::PH_ST1;
            i2cm_pkg::PH_ST1:     target = i2cm_pkg::PH_ST2;
            i2cm_pkg::PH_SP0:     target = i2cm_pkg::PH_SP1;
            i2cm_pkg::PH_SP1:     target = i2cm_pkg::PH_SP2;
            i2cm_pkg::PH_WB_SET:  target = i2cm_pkg::PH_WB_HIGH;
            i2cm_pkg::PH_WB_HIGH: target = i2cm_pkg::PH_WB_LOW;
            i2cm_pkg::PH_WB_LOW: begin
              state_next.shift_reg = {state.shift_reg[6:0], 1'b0};
              state_next.bit_count = count_inc;
              target = count_inc[3] ? i2cm_pkg::PH_WA_REL : i2cm_pkg::PH_WB_SET;
            end
            i2cm_pkg::PH_WA_REL:  target = i2cm_pkg::PH_WA_HIGH;
            i2cm_pkg::PH_WA_HIGH: begin
              state_next.poll_count = 8'd0;
              target = i2cm_pkg::PH_WA_POLL;
            end
            i2cm_pkg::PH_RB_LOW:  target = i2cm_pkg::PH_RB_HIGH;
            i2cm_pkg::PH_RB_HIGH: begin
              state_next.shift_reg = {state.shift_reg[6:0], cmd.sda_in};
              state_next.bit_count = count_inc;
              target = count_inc[3] ? i2cm_pkg::PH_RA_SET : i2cm_pkg::PH_RB_LOW;
            end
            i2cm_pkg::PH_RA_SET:  target = i2cm_pkg::PH_RA_HIGH;
            i2cm_pkg::PH_RA_HIGH: target = i2cm_pkg::PH_RA_LOW;
            default: begin
              // End of the last phase of a command: back to idle, drives kept.
              if (state.phase == i2cm_pkg::PH_RA_LOW) begin
                state_next.rx_hold = state.shift_reg;
              end
              go                     = 1'b0;
              state_next.phase       = i2cm_pkg::PH_IDLE;
              state_next.phase_timer = 16'd0;
              state_next.done        = 1'b1;
            end
          endcase
        end
      end
    endcase

    if (go) begin
      state_next.phase       = target;
      state_next.phase_timer = 16'd0;
      {state_next.scl_reg, state_next.sda_reg} =
        drive_of(target, state_next.shift_reg[7], !state_next.ack_choice,
                 {state.scl_reg, state.sda_reg});
    end
  end

endmodule

/* rtl/i2c_master_byte_engine_core.sv */
// I2C master byte engine top level: one command beat is one bus tick.
// The response beat for a command beat is registered and valid in the cycle after acceptance.
// One beat per cycle unless rsp_ready stalls; a taken response is refilled in that cycle.
// Reset (rst, synchronous): bus released high, sequencer idle, registers at defaults.
// Depends on i2cm_pkg and i2cm_fsm.
module i2c_master_byte_engine_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cmd_valid,
  output logic                                 cmd_ready,
  input  i2cm_pkg::cmd_t                       cmd,
  output logic                                 rsp_valid,
  input  logic                                 rsp_ready,
  output i2cm_pkg::rsp_t                       rsp,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [i2cm_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [i2cm_pkg::CFG_DATA_W-1:0]      cfg_data
);

  i2cm_pkg::eng_state_t state;
  i2cm_pkg::eng_state_t state_next;
  logic [15:0]          ticks_per_phase;
  logic [7:0]           ack_poll_limit;
  logic                 cmd_fire;

  assign cfg_ready = 1'b1;
  assign cmd_ready = !rsp_valid || rsp_ready;
  assign cmd_fire  = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_phase <= i2cm_pkg::TICKS_PER_PHASE_RESET;
      ack_poll_limit  <= i2cm_pkg::ACK_POLL_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        i2cm_pkg::CFG_TICKS_PER_PHASE: ticks_per_phase <= cfg_data;
        i2cm_pkg::CFG_ACK_POLL_LIMIT:  ack_poll_limit  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  i2cm_fsm u_fsm (
    .state           (state),
    .cmd             (cmd),
    .ticks_per_phase (ticks_per_phase),
    .ack_poll_limit  (ack_poll_limit),
    .state_next      (state_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase       <= i2cm_pkg::PH_IDLE;
      state.bit_count   <= 4'd0;
      state.shift_reg   <= 8'd0;
      state.phase_timer <= 16'd0;
      state.poll_count  <= 8'd0;
      state.ack_choice  <= 1'b0;
      state.scl_reg     <= 1'b1;
      state.sda_reg     <= 1'b1;
      state.rx_hold     <= 8'd0;
      state.nack_flag   <= 1'b0;
      state.done        <= 1'b0;
      rsp_valid         <= 1'b0;
    end else begin
      if (cmd_fire) begin
        state     <= state_next;
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // The state registers double as the response register.
  assign rsp.scl_level = state.scl_reg;
  assign rsp.sda_level = state.sda_reg;
  assign rsp.busy_res  = (state.phase != i2cm_pkg::PH_IDLE);
  assign rsp.done_res  = state.done;
  assign rsp.rx_byte   = state.rx_hold;
  assign rsp.no_ack    = state.nack_flag;

endmodule

/* rtl/i2cm_chk.sv */
// Port-level checker for the I2C master byte engine, bound to the top level.
// Depends on i2cm_pkg and i2c_master_byte_engine_core.
module i2cm_chk (
  input logic           clk,
  input logic           rst,
  input logic           cmd_valid,
  input logic           cmd_ready,
  input logic           rsp_valid,
  input logic           rsp_ready,
  input i2cm_pkg::rsp_t rsp
);

  // A finished command leaves the sequencer idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.done_res |-> !rsp.busy_res)
    else $error("done beat shows busy");

  // A response beat only follows an accepted command beat.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    (!rsp_valid || rsp_ready) && !(cmd_valid && cmd_ready) |=> !rsp_valid)
    else $error("response beat without command beat");

  // With the response slot empty, a command beat is always taken.
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !rsp_valid |-> cmd_ready)
    else $error("command stalled with empty response slot");

  // A stalled response beat holds.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("stalled response beat changed");

endmodule

bind i2c_master_byte_engine_core i2cm_chk u_i2cm_chk (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd_valid),
  .cmd_ready (cmd_ready),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);
